@@ rtl/core/emi_pkg.sv @@
// Shared types, constants and saturation helpers for the entity motion integrator.
// Used by emi_axis and entity_motion_integrator; depends on nothing else.
package emi_pkg;

    localparam int unsigned NUM_STAGES = 5;
    localparam logic [16:0] ONE_Q16    = 17'd65536;

    typedef enum logic [2:0] {
        REG_DRAG_X        = 3'd0,
        REG_DRAG_Y        = 3'd1,
        REG_STOP_THRESH   = 3'd2,
        REG_WRAP_ENABLE   = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_SPRITE_WIDTH  = 3'd6,
        REG_SPRITE_HEIGHT = 3'd7
    } reg_idx_t;

    // Per-axis settings derived from the configuration registers.
    typedef struct packed {
        logic [16:0]        factor;     // 1 - drag, unsigned Q1.16
        logic               stop_en;
        logic [30:0]        thresh;
        logic               wrap_en;
        logic signed [31:0] hi;         // screen size, Q16.16
        logic signed [31:0] lo;         // minus sprite size, Q16.16
        logic               spin_mode;  // fixed-step position takes the new velocity
    } axis_cfg_t;

    function automatic logic signed [48:0] sext49(input logic signed [31:0] v);
        return {{17{v[31]}}, v};
    endfunction

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
        logic in_range;
        in_range = (&x[48:31]) || !(|x[48:31]);
        if (in_range) begin
            return x[31:0];
        end else if (x[48]) begin
            return {1'b1, 31'd0};
        end else begin
            return {1'b0, {31{1'b1}}};
        end
    endfunction

endpackage

@@ rtl/core/emi_axis.sv @@
// Five-stage datapath for one axis: velocity and position update, drag, stop and wrap.
// Depends on emi_pkg; stage load enables come from the top-level flow control.
module emi_axis import emi_pkg::*; (
    input  logic                  aclk,
    input  logic [NUM_STAGES-1:0] stage_en,
    input  axis_cfg_t             cfg,
    input  logic signed [31:0]    pos,
    input  logic signed [31:0]    vel,
    input  logic signed [31:0]    acc,
    input  logic                  fixed_step,
    input  logic [31:0]           elapsed,
    output logic signed [31:0]    new_pos,
    output logic signed [31:0]    new_vel,
    output logic signed [31:0]    new_acc
);

    // Stage 1: capture and form acc * dt.
    logic signed [31:0] pos_s1_reg, vel_s1_reg, acc_s1_reg;
    logic [31:0]        dt_s1_reg;
    logic               fix_s1_reg;
    logic signed [63:0] prod_s1_reg;
    logic signed [64:0] prod_s1_full;
    logic signed [63:0] prod_s1_next;

    // Stage 2: new velocity, fixed-step position.
    logic signed [31:0] pos_s2_reg, vel_s2_reg, acc_s2_reg, pfix_s2_reg;
    logic [31:0]        dt_s2_reg;
    logic               fix_s2_reg;
    logic signed [48:0] vel_term;
    logic signed [31:0] vel_s2_next, pfix_s2_next;

    // Stage 3: velocity times drag factor or dt.
    logic signed [31:0] pos_s3_reg, vel_s3_reg, acc_s3_reg, pfix_s3_reg;
    logic               fix_s3_reg;
    logic signed [63:0] prod_s3_reg;
    logic [31:0]        mul_b;
    logic signed [64:0] prod_s3_full;
    logic signed [63:0] prod_s3_next;
    logic signed [31:0] pfix_s3_next;

    // Stage 4: final velocity and unwrapped position.
    logic signed [31:0] pos_s4_reg, vel_s4_reg, acc_s4_reg;
    logic signed [48:0] prod_shift;
    logic signed [31:0] scaled;
    logic signed [32:0] scaled_ext;
    logic [32:0]        mag;
    logic signed [31:0] stopped;
    logic signed [31:0] pos_s4_next, vel_s4_next, acc_s4_next;

    // Stage 5: screen wrap into the output registers.
    logic signed [31:0] pos_s5_reg, vel_s5_reg, acc_s5_reg;
    logic signed [31:0] pos_s5_next;

    assign prod_s1_full = acc * $signed({1'b0, elapsed});
    assign prod_s1_next = prod_s1_full[63:0];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            pos_s1_reg  <= pos;
            vel_s1_reg  <= vel;
            acc_s1_reg  <= acc;
            dt_s1_reg   <= elapsed;
            fix_s1_reg  <= fixed_step;
            prod_s1_reg <= prod_s1_next;
        end
    end

    always_comb begin
        if (fix_s1_reg) begin
            vel_term = sext49(acc_s1_reg);
        end else begin
            vel_term = {prod_s1_reg[63], prod_s1_reg[63:16]};
        end
        vel_s2_next  = sat32(sext49(vel_s1_reg) + vel_term);
        pfix_s2_next = sat32(sext49(pos_s1_reg) + sext49(vel_s1_reg));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            pos_s2_reg  <= pos_s1_reg;
            vel_s2_reg  <= vel_s2_next;
            acc_s2_reg  <= acc_s1_reg;
            pfix_s2_reg <= pfix_s2_next;
            dt_s2_reg   <= dt_s1_reg;
            fix_s2_reg  <= fix_s1_reg;
        end
    end

    always_comb begin
        mul_b        = fix_s2_reg ? {15'd0, cfg.factor} : dt_s2_reg;
        prod_s3_full = vel_s2_reg * $signed({1'b0, mul_b});
        prod_s3_next = prod_s3_full[63:0];
        // In fixed-step mode, rotation advances by the updated rate, linear axes by the old velocity.
        if (cfg.spin_mode) begin
            pfix_s3_next = sat32(sext49(pos_s2_reg) + sext49(vel_s2_reg));
        end else begin
            pfix_s3_next = pfix_s2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            pos_s3_reg  <= pos_s2_reg;
            vel_s3_reg  <= vel_s2_reg;
            acc_s3_reg  <= acc_s2_reg;
            pfix_s3_reg <= pfix_s3_next;
            fix_s3_reg  <= fix_s2_reg;
            prod_s3_reg <= prod_s3_next;
        end
    end

    always_comb begin
        prod_shift = {prod_s3_reg[63], prod_s3_reg[63:16]};
        scaled     = sat32(prod_shift);
        scaled_ext = {scaled[31], scaled};
        mag        = scaled_ext[32] ? 33'(-scaled_ext) : 33'(scaled_ext);
        if (cfg.stop_en && (mag <= {2'b00, cfg.thresh})) begin
            stopped = '0;
        end else begin
            stopped = scaled;
        end
        if (fix_s3_reg) begin
            vel_s4_next = stopped;
            pos_s4_next = pfix_s3_reg;
            acc_s4_next = '0;
        end else begin
            vel_s4_next = vel_s3_reg;
            pos_s4_next = sat32(sext49(pos_s3_reg) + prod_shift);
            acc_s4_next = acc_s3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            pos_s4_reg <= pos_s4_next;
            vel_s4_reg <= vel_s4_next;
            acc_s4_reg <= acc_s4_next;
        end
    end

    always_comb begin
        pos_s5_next = pos_s4_reg;
        if (cfg.wrap_en) begin
            if (pos_s4_reg > cfg.hi) begin
                pos_s5_next = cfg.lo;
            end else if (pos_s4_reg < cfg.lo) begin
                pos_s5_next = cfg.hi;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            pos_s5_reg <= pos_s5_next;
            vel_s5_reg <= vel_s4_reg;
            acc_s5_reg <= acc_s4_reg;
        end
    end

    assign new_pos = pos_s5_reg;
    assign new_vel = vel_s5_reg;
    assign new_acc = acc_s5_reg;

endmodule

@@ rtl/core/entity_motion_integrator.sv @@
// Entity motion integrator top level: configuration registers, flow control and
// three axis datapaths (horizontal, vertical, rotation). Depends on emi_pkg and emi_axis.
//
// Usage: motion records arrive on the s_ channel (valid/ready) and updated records
// leave on the m_ channel (valid/ready), one result per record, in order.
// The datapath is a five-stage pipeline; a record accepted into the first stage register
// moves through the stage registers in order and raises m_valid once it reaches the
// fifth, the output register, where a stalled output side holds it until m_ready.
// One record is accepted per cycle for as long as the receiver keeps taking results,
// since every stage hands its record on as the next one loads: stages one and three
// hold the multiplies, two and four the saturating adds, and five the screen wrap.
// When the receiver holds m_ready low, stages fill up behind the output register
// and s_ready drops only once every stage holds a record; bubbles are squeezed out.
// The user must write settings over the APB-style port while no transfer is in flight
// (the block does not enforce it); pready is always high; reads return the stored value.
// A synchronous active-low reset empties the pipeline and loads the register defaults:
// no drag, stop threshold 655, wrap off, screen 800 by 600, sprite 0 by 0.
module entity_motion_integrator import emi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    input  logic signed [31:0] s_acc_x,
    input  logic signed [31:0] s_acc_y,
    input  logic signed [31:0] s_angle,
    input  logic signed [31:0] s_spin_rate,
    input  logic signed [31:0] s_spin_accel,
    input  logic               s_fixed_step,
    input  logic [31:0]        s_elapsed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_new_pos_x,
    output logic signed [31:0] m_new_pos_y,
    output logic signed [31:0] m_new_vel_x,
    output logic signed [31:0] m_new_vel_y,
    output logic signed [31:0] m_new_angle,
    output logic signed [31:0] m_new_spin_rate,
    output logic signed [31:0] m_new_acc_x,
    output logic signed [31:0] m_new_acc_y
);

    logic [16:0] drag_x_reg, drag_y_reg;
    logic [30:0] stop_thresh_reg;
    logic        wrap_enable_reg;
    logic [12:0] screen_width_reg, screen_height_reg;
    logic [12:0] sprite_width_reg, sprite_height_reg;
    logic        cfg_write;
    reg_idx_t    reg_idx;

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] stage_rdy;

    logic [16:0] drag_x_lim, drag_y_lim;
    axis_cfg_t   cfg_x, cfg_y, cfg_rot;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drag_x_reg        <= '0;
            drag_y_reg        <= '0;
            stop_thresh_reg   <= 31'd655;
            wrap_enable_reg   <= 1'b0;
            screen_width_reg  <= 13'd800;
            screen_height_reg <= 13'd600;
            sprite_width_reg  <= '0;
            sprite_height_reg <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_DRAG_X:        drag_x_reg        <= pwdata[16:0];
                REG_DRAG_Y:        drag_y_reg        <= pwdata[16:0];
                REG_STOP_THRESH:   stop_thresh_reg   <= pwdata[30:0];
                REG_WRAP_ENABLE:   wrap_enable_reg   <= pwdata[0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[12:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[12:0];
                REG_SPRITE_WIDTH:  sprite_width_reg  <= pwdata[12:0];
                REG_SPRITE_HEIGHT: sprite_height_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DRAG_X:        prdata = {15'd0, drag_x_reg};
            REG_DRAG_Y:        prdata = {15'd0, drag_y_reg};
            REG_STOP_THRESH:   prdata = {1'b0, stop_thresh_reg};
            REG_WRAP_ENABLE:   prdata = {31'd0, wrap_enable_reg};
            REG_SCREEN_WIDTH:  prdata = {19'd0, screen_width_reg};
            REG_SCREEN_HEIGHT: prdata = {19'd0, screen_height_reg};
            REG_SPRITE_WIDTH:  prdata = {19'd0, sprite_width_reg};
            REG_SPRITE_HEIGHT: prdata = {19'd0, sprite_height_reg};
            default:           prdata = '0;
        endcase
    end

    // A drag setting above one acts as one, which leaves a zero factor.
    always_comb begin
        drag_x_lim = (drag_x_reg > ONE_Q16) ? ONE_Q16 : drag_x_reg;
        drag_y_lim = (drag_y_reg > ONE_Q16) ? ONE_Q16 : drag_y_reg;

        cfg_x.factor    = ONE_Q16 - drag_x_lim;
        cfg_x.stop_en   = 1'b1;
        cfg_x.thresh    = stop_thresh_reg;
        cfg_x.wrap_en   = wrap_enable_reg;
        cfg_x.hi        = {3'd0, screen_width_reg, 16'd0};
        cfg_x.lo        = 32'sd0 - $signed({3'd0, sprite_width_reg, 16'd0});
        cfg_x.spin_mode = 1'b0;

        cfg_y.factor    = ONE_Q16 - drag_y_lim;
        cfg_y.stop_en   = 1'b1;
        cfg_y.thresh    = stop_thresh_reg;
        cfg_y.wrap_en   = wrap_enable_reg;
        cfg_y.hi        = {3'd0, screen_height_reg, 16'd0};
        cfg_y.lo        = 32'sd0 - $signed({3'd0, sprite_height_reg, 16'd0});
        cfg_y.spin_mode = 1'b0;

        // Rotation has no drag, no stop threshold and no wrap.
        cfg_rot.factor    = ONE_Q16;
        cfg_rot.stop_en   = 1'b0;
        cfg_rot.thresh    = '0;
        cfg_rot.wrap_en   = 1'b0;
        cfg_rot.hi        = '0;
        cfg_rot.lo        = '0;
        cfg_rot.spin_mode = 1'b1;
    end

    // A stage may load when it is empty or when the stage after it loads as well.
    always_comb begin
        stage_rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_rdy[i] = !vld_reg[i] || stage_rdy[i+1];
        end
        vld_next = vld_reg;
        if (stage_rdy[0]) begin
            vld_next[0] = s_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_rdy[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = stage_rdy[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    emi_axis u_axis_x (
        .aclk       (aclk),
        .stage_en   (stage_rdy),
        .cfg        (cfg_x),
        .pos        (s_pos_x),
        .vel        (s_vel_x),
        .acc        (s_acc_x),
        .fixed_step (s_fixed_step),
        .elapsed    (s_elapsed),
        .new_pos    (m_new_pos_x),
        .new_vel    (m_new_vel_x),
        .new_acc    (m_new_acc_x)
    );

    emi_axis u_axis_y (
        .aclk       (aclk),
        .stage_en   (stage_rdy),
        .cfg        (cfg_y),
        .pos        (s_pos_y),
        .vel        (s_vel_y),
        .acc        (s_acc_y),
        .fixed_step (s_fixed_step),
        .elapsed    (s_elapsed),
        .new_pos    (m_new_pos_y),
        .new_vel    (m_new_vel_y),
        .new_acc    (m_new_acc_y)
    );

    emi_axis u_axis_rot (
        .aclk       (aclk),
        .stage_en   (stage_rdy),
        .cfg        (cfg_rot),
        .pos        (s_angle),
        .vel        (s_spin_rate),
        .acc        (s_spin_accel),
        .fixed_step (s_fixed_step),
        .elapsed    (s_elapsed),
        .new_pos    (m_new_angle),
        .new_vel    (m_new_spin_rate),
        .new_acc    ()
    );

endmodule
